/* design/sdq_pkg.sv */
package sdq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int REQ_TYPE_W   = 3;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 2;
   localparam int ITEM_COUNT_W = 6;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_PEEK_FRONT,
      OP_PEEK_BACK,
      OP_INSERT
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE,
      ST_EMPTY,
      ST_FULL
   } status_type;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      data_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } mem_ctl_type;

   typedef struct packed {
      logic                    valid;
      logic [VALUE_W-1:0]      result_value;
      status_type              status;
      logic [ITEM_COUNT_W-1:0] item_count;
   } done_type;

   function automatic idx_type wrap_inc(idx_type i);
      return (i == idx_type'(DEPTH - 1)) ? '0 : i + idx_type'(1);
   endfunction

   function automatic idx_type wrap_dec(idx_type i);
      return (i == '0) ? idx_type'(DEPTH - 1) : i - idx_type'(1);
   endfunction

endpackage

/* design/sdq_ifs.sv */
interface sdq_req_if import sdq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [VALUE_W-1:0]    data_value;

   modport source (output valid, output req_type, output data_value, input ready);
   modport sink (input valid, input req_type, input data_value, output ready);
endinterface

interface sdq_rsp_if import sdq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [VALUE_W-1:0]      result_value;
   logic [STATUS_W-1:0]     status;
   logic [ITEM_COUNT_W-1:0] item_count;

   modport source (output valid, output result_value, output status, output item_count,
                   input ready);
   modport sink (input valid, input result_value, input status, input item_count,
                 output ready);
endinterface

/* design/sdq_store.sv */
module sdq_store import sdq_pkg::*; (
   input  logic        clock,
   input  mem_ctl_type mem_ctl,
   output data_type    rd_data
);

   data_type slot_mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         slot_mem[mem_ctl.wr_addr] <= mem_ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= slot_mem[mem_ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sdq_ctrl.sv */
module sdq_ctrl import sdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  op_type      req_op,
   input  data_type    req_data,
   output logic        idle,
   input  logic        out_free,
   output done_type    done,
   output mem_ctl_type mem_ctl,
   input  data_type    rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_WAIT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   idx_type            front_ff, front_in;
   idx_type            back_ff, back_in;
   idx_type            count_ff, count_in;
   idx_type            pos_ff, pos_in;
   data_type           value_ff, value_in;
   logic [VALUE_W-1:0] result_ff, result_in;
   status_type         status_ff, status_in;

   logic                full;
   logic                empty;
   idx_type             k_sel;
   logic [IDX_W:0]      slot_sum;
   idx_type             slot_addr;

   assign full  = (count_ff == idx_type'(DEPTH - 1));
   assign empty = (count_ff == '0);

   // Shared address unit: slot of logical position k is (front + k) mod DEPTH.
   always_comb begin
      if (state_ff == S_SCAN_RD && pos_ff != '0) begin
         k_sel = pos_ff - idx_type'(1);
      end else begin
         k_sel = pos_ff;
      end
      slot_sum = {1'b0, front_ff} + {1'b0, k_sel};
      if (slot_sum >= (IDX_W + 1)'(DEPTH)) begin
         slot_addr = IDX_W'(slot_sum - (IDX_W + 1)'(DEPTH));
      end else begin
         slot_addr = slot_sum[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      value_in  = value_ff;
      result_in = result_ff;
      status_in = status_ff;
      mem_ctl   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               value_in  = req_data;
               result_in = '0;
               status_in = ST_DONE;
               state_in  = S_RESP;
               unique case (req_op)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        front_in        = wrap_dec(front_ff);
                        count_in        = count_ff + idx_type'(1);
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.wr_addr = wrap_dec(front_ff);
                        mem_ctl.wr_data = req_data;
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        back_in         = wrap_inc(back_ff);
                        count_in        = count_ff + idx_type'(1);
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.wr_addr = back_ff;
                        mem_ctl.wr_data = req_data;
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in   = count_ff;
                        state_in = S_SCAN_RD;
                     end
                  end
                  OP_POP_FRONT, OP_PEEK_FRONT: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_ctl.rd_en   = 1'b1;
                        mem_ctl.rd_addr = front_ff;
                        state_in        = S_RD_WAIT;
                        if (req_op == OP_POP_FRONT) begin
                           front_in = wrap_inc(front_ff);
                           count_in = count_ff - idx_type'(1);
                        end
                     end
                  end
                  OP_POP_BACK, OP_PEEK_BACK: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_ctl.rd_en   = 1'b1;
                        mem_ctl.rd_addr = wrap_dec(back_ff);
                        state_in        = S_RD_WAIT;
                        if (req_op == OP_POP_BACK) begin
                           back_in  = wrap_dec(back_ff);
                           count_in = count_ff - idx_type'(1);
                        end
                     end
                  end
                  default: begin
                     // unknown request: report done, leave the queue alone
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            result_in = VALUE_W'(rd_data);
            state_in  = S_RESP;
         end
         S_SCAN_RD: begin
            if (pos_ff == '0) begin
               // nothing left below: value becomes the new front
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_addr = slot_addr;
               mem_ctl.wr_data = value_ff;
               back_in         = wrap_inc(back_ff);
               count_in        = count_ff + idx_type'(1);
               state_in        = S_RESP;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = slot_addr;
               state_in        = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = slot_addr;
            if (rd_data <= value_ff) begin
               mem_ctl.wr_data = value_ff;
               back_in         = wrap_inc(back_ff);
               count_in        = count_ff + idx_type'(1);
               state_in        = S_RESP;
            end else begin
               // move the larger entry one slot toward the back and keep scanning
               mem_ctl.wr_data = rd_data;
               pos_in          = pos_ff - idx_type'(1);
               state_in        = S_SCAN_RD;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

   assign idle              = (state_ff == S_IDLE);
   assign done.valid        = (state_ff == S_RESP);
   assign done.result_value = result_ff;
   assign done.status       = status_ff;
   assign done.item_count   = ITEM_COUNT_W'(count_ff);

endmodule

/* design/sorted_deque_ring_buffer.sv */
// From accept, push, full, empty and unknown requests go straight to the response state;
// pop and peek pass a read wait state first; a sorted insert moves each larger stored entry
// one slot toward the back until an entry no larger than the value stops the scan or the
// value becomes the new front (an insert into an empty queue included). The controller
// takes one request at a time; the next is taken no earlier than the edge at which the
// previous response can be taken. Reset (synchronous, active high) clears the indices, the
// count and the response valid; the slot store is not cleared and needs no clearing pass.
module sorted_deque_ring_buffer import sdq_pkg::*; (
   input logic      clock,
   input logic      reset,
   sdq_req_if.sink  req_bus,
   sdq_rsp_if.source rsp_bus
);

   logic        req_fire;
   logic        ctrl_idle;
   logic        out_free;
   done_type    done;
   mem_ctl_type mem_ctl;
   data_type    rd_data;

   logic                    rsp_valid_ff;
   logic [VALUE_W-1:0]      rsp_result_ff;
   status_type              rsp_status_ff;
   logic [ITEM_COUNT_W-1:0] rsp_count_ff;

   assign req_bus.ready = ctrl_idle;
   assign req_fire      = req_bus.valid && ctrl_idle;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   sdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_op   (op_type'(req_bus.req_type)),
      .req_data (data_type'(req_bus.data_value)),
      .idle     (ctrl_idle),
      .out_free (out_free),
      .done     (done),
      .mem_ctl  (mem_ctl),
      .rd_data  (rd_data)
   );

   sdq_store u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_data (rd_data)
   );

   // Output register: hold the response until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done.valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done.valid && out_free) begin
         rsp_result_ff <= done.result_value;
         rsp_status_ff <= done.status;
         rsp_count_ff  <= done.item_count;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_result_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.item_count   = rsp_count_ff;

endmodule

/* design/sdq_checker.sv */
module sdq_checker import sdq_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [VALUE_W-1:0]      rsp_result_value,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [ITEM_COUNT_W-1:0] rsp_item_count
);

   // one request at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == ST_FULL
      |-> rsp_item_count == ITEM_COUNT_W'(DEPTH - 1))
      else $error("full status with room left");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == ST_EMPTY
      |-> rsp_item_count == '0 && rsp_result_value == '0)
      else $error("empty status with stored items or nonzero value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
      |=> rsp_valid && $stable(rsp_result_value) && $stable(rsp_status)
          && $stable(rsp_item_count))
      else $error("stalled response changed");

endmodule

bind sorted_deque_ring_buffer sdq_checker u_sdq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_value (rsp_bus.result_value),
   .rsp_status       (rsp_bus.status),
   .rsp_item_count   (rsp_bus.item_count)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import sdq_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] OP_UNKNOWN = 3'd7;
   localparam int                    ITEM_GOAL  = 450;
   localparam int                    IDLE_LIMIT = 3000;

   typedef struct {
      logic [VALUE_W-1:0]      value;
      status_type              status;
      logic [ITEM_COUNT_W-1:0] count;
   } deque_rsp_type;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_SORTED} phase_kind_type;

   // Mirror of the deque contents; computes the response each request must produce.
   class deque_scoreboard_type;
      data_type      slots [DEPTH];
      idx_type       front_slot;
      idx_type       back_slot;
      int unsigned   held;
      int unsigned   max_held;
      int unsigned   full_seen;
      int unsigned   empty_seen;
      int unsigned   mismatches;
      deque_rsp_type expected_rsp [$];

      function new();
         front_slot = '0;
         back_slot  = '0;
         held       = 0;
         max_held   = 0;
         full_seen  = 0;
         empty_seen = 0;
         mismatches = 0;
      endfunction

      function idx_type step_up(idx_type i);
         return idx_type'((int'(i) + 1) % DEPTH);
      endfunction

      function idx_type step_down(idx_type i);
         return idx_type'((int'(i) + DEPTH - 1) % DEPTH);
      endfunction

      function idx_type slot_at(int unsigned k);
         return idx_type'((int'(front_slot) + k) % DEPTH);
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction

      function void add_back(data_type v);
         slots[back_slot] = v;
         back_slot = step_up(back_slot);
         held++;
      endfunction

      function void place_sorted(data_type v);
         int unsigned pos;
         pos = 0;
         if (held == 0 || v > slots[step_down(back_slot)]) begin
            add_back(v);
            return;
         end
         // last entry <= v, scanning from the back; none found means new front
         for (int unsigned k = held; k > 0; k--) begin
            if (slots[slot_at(k - 1)] <= v) begin
               pos = k;
               break;
            end
         end
         for (int unsigned k = held; k > pos; k--)
            slots[slot_at(k)] = slots[slot_at(k - 1)];
         slots[slot_at(pos)] = v;
         back_slot = step_up(back_slot);
         held++;
      endfunction

      function void note_request(logic [REQ_TYPE_W-1:0] code, logic [VALUE_W-1:0] data);
         deque_rsp_type rsp;
         data_type      v;
         logic          no_room;
         logic          no_items;
         rsp.value  = '0;
         rsp.status = ST_DONE;
         v          = data_type'(data);
         no_room    = (held >= DEPTH - 1);
         no_items   = (held == 0);
         case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
               if (no_room) begin
                  rsp.status = ST_FULL;
               end else if (code == OP_PUSH_FRONT) begin
                  front_slot = step_down(front_slot);
                  slots[front_slot] = v;
                  held++;
               end else if (code == OP_PUSH_BACK) begin
                  add_back(v);
               end else begin
                  place_sorted(v);
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               if (no_items) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  rsp.value = VALUE_W'(slots[front_slot]);
                  if (code == OP_POP_FRONT) begin
                     front_slot = step_up(front_slot);
                     held--;
                  end
               end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               if (no_items) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  rsp.value = VALUE_W'(slots[step_down(back_slot)]);
                  if (code == OP_POP_BACK) begin
                     back_slot = step_down(back_slot);
                     held--;
                  end
               end
            end
            default: ;
         endcase
         if (rsp.status == ST_FULL) full_seen++;
         if (rsp.status == ST_EMPTY) empty_seen++;
         if (held > max_held) max_held = held;
         rsp.count = ITEM_COUNT_W'(held);
         expected_rsp.insert(expected_rsp.size(), rsp);
      endfunction

      function void check_response(logic [VALUE_W-1:0] value, logic [STATUS_W-1:0] status,
                                   logic [ITEM_COUNT_W-1:0] count);
         deque_rsp_type exp_rsp;
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding: value %h status %0d count %0d",
                   value, status, count);
            mismatches++;
            return;
         end
         exp_rsp = expected_rsp[0];
         expected_rsp.delete(0);
         if (value !== exp_rsp.value) begin
            $error("result_value: expected %h, got %h", exp_rsp.value, value);
            mismatches++;
         end
         if (status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, status);
            mismatches++;
         end
         if (count !== exp_rsp.count) begin
            $error("item_count: expected %0d, got %0d", exp_rsp.count, count);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdq_req_if req_if ();
   sdq_rsp_if rsp_if ();

   sorted_deque_ring_buffer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   deque_scoreboard_type sb;
   int unsigned          op_seen [8];
   int unsigned          burst_left = 0;
   logic [7:0]           stall_pattern = '0;
   int unsigned          pattern_age = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: ready follows a rotating pattern that is reloaded now and then.
   initial rsp_if.ready = 1'b0;
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         pattern_age = $urandom_range(16, 64);
         case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = 8'($urandom);
            2: stall_pattern = 8'h01;
            default: stall_pattern = 8'($urandom) | 8'h11;
         endcase
      end
      pattern_age--;
      stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      rsp_if.ready <= stall_pattern[0];
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.result_value, rsp_if.status, rsp_if.item_count);
   end

   // End the run once nothing moves on either channel for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_request(input logic [REQ_TYPE_W-1:0] code,
                               input logic [VALUE_W-1:0] data);
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.req_type   <= code;
      req_if.data_value <= data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(code, data);
      op_seen[code]++;
   endtask

   task automatic idle_gap(input int unsigned cycles);
      @(negedge clock);
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_TYPE_W'($urandom);
      req_if.data_value <= $urandom;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Send in bursts; open each burst with a random gap.
   task automatic issue(input logic [REQ_TYPE_W-1:0] code, input logic [VALUE_W-1:0] data);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0)
            idle_gap($urandom_range(5, 20));
         else
            idle_gap($urandom_range(1, 3));
         burst_left = $urandom_range(1, 40);
      end
      send_request(code, data);
      burst_left--;
   endtask

   // Drop valid first so the last request is not taken again while waiting.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 5))
         0, 1: return $urandom_range(0, 15);
         2: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               2: return 32'h8000_0000;
               default: return 32'h7fff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [REQ_TYPE_W-1:0] draw_op(phase_kind_type phase);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PH_FILL: begin
            if (roll < 45) return OP_INSERT;
            if (roll < 65) return OP_PUSH_BACK;
            if (roll < 80) return OP_PUSH_FRONT;
            if (roll < 89) return roll[0] ? OP_PEEK_FRONT : OP_PEEK_BACK;
            if (roll < 97) return roll[0] ? OP_POP_FRONT : OP_POP_BACK;
            return OP_UNKNOWN;
         end
         PH_DRAIN: begin
            if (roll < 35) return OP_POP_FRONT;
            if (roll < 70) return OP_POP_BACK;
            if (roll < 80) return roll[0] ? OP_PEEK_FRONT : OP_PEEK_BACK;
            if (roll < 90) return OP_INSERT;
            return roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
         end
         PH_SORTED: begin
            if (roll < 60) return OP_INSERT;
            if (roll < 85) return OP_POP_FRONT;
            if (roll < 95) return OP_PEEK_FRONT;
            return OP_POP_BACK;
         end
         default: begin
            if (roll < 3) return OP_UNKNOWN;
            return REQ_TYPE_W'(op_type'($urandom_range(0, 6)));
         end
      endcase
   endfunction

   initial begin
      int unsigned           counted;
      int unsigned           phase_len;
      int unsigned           phase_no;
      phase_kind_type        phase;
      logic [REQ_TYPE_W-1:0] code;
      sb = new();
      req_if.valid      = 1'b0;
      req_if.req_type   = '0;
      req_if.data_value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty reads, ignored code, each insert placement, then pushes, peeks and pops
      issue(OP_POP_FRONT, 32'hffff_ffff);
      issue(OP_POP_BACK, '0);
      issue(OP_PEEK_FRONT, $urandom);
      issue(OP_PEEK_BACK, $urandom);
      issue(OP_UNKNOWN, 32'hdead_beef);
      issue(OP_INSERT, 32'h8000_0000);
      issue(OP_INSERT, 32'hffff_ffff);
      issue(OP_INSERT, '0);
      issue(OP_INSERT, 32'h8000_0000);
      issue(OP_INSERT, 32'h7fff_ffff);
      issue(OP_PUSH_FRONT, 32'h1234_5678);
      issue(OP_PUSH_BACK, 32'ha5a5_a5a5);
      issue(OP_PEEK_FRONT, '0);
      issue(OP_PEEK_BACK, '0);
      issue(OP_INSERT, 32'h5555_5555);
      issue(OP_UNKNOWN, '1);
      issue(OP_POP_FRONT, '0);
      issue(OP_POP_BACK, '0);
      issue(OP_PEEK_BACK, '0);
      issue(OP_POP_FRONT, '0);
      issue(OP_INSERT, 32'h0000_0001);
      wait_drained();

      counted  = 0;
      phase_no = 0;
      while (counted < ITEM_GOAL) begin
         // open with a long fill to reach full, then a long drain to reach empty
         if (phase_no == 0) begin
            phase     = PH_FILL;
            phase_len = 90;
         end else if (phase_no == 1) begin
            phase     = PH_DRAIN;
            phase_len = 90;
         end else begin
            phase     = phase_kind_type'($urandom_range(0, 3));
            phase_len = $urandom_range(20, 90);
         end
         repeat (phase_len) begin
            code = draw_op(phase);
            issue(code, draw_value());
            if (code != OP_UNKNOWN) counted++;
         end
         if (phase_no == 0 || $urandom_range(0, 2) == 0) wait_drained();
         phase_no++;
      end

      idle_gap(1);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Run: %0d requests over %0d phases, %0d ignored codes, %0d inserts.",
               op_seen.sum(), phase_no, op_seen[OP_UNKNOWN], op_seen[OP_INSERT]);
      $display("Full drops %0d, empty reads %0d, peak occupancy %0d of %0d.",
               sb.full_seen, sb.empty_seen, sb.max_held, DEPTH - 1);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
design/sdq_pkg.sv
design/sdq_ifs.sv
design/sdq_store.sv
design/sdq_ctrl.sv
design/sorted_deque_ring_buffer.sv
design/sdq_checker.sv
tb/tb.sv
